>>> sv/wf2d_pkg.sv
// Shared types, constants and helpers for the 2D waypoint follower.
// Used by wf2d_ctrl, wf2d_dp, waypoint_follower_2d and wf2d_chk.
package wf2d_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // fixed arithmetic widths (Q16.16 positions)
  localparam int unsigned POS_W      = 32;
  localparam int unsigned MAG_W      = 34;  // |dx|, |dy|, distance
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned RATIO_W    = 30;
  localparam int unsigned RAD_W      = 68;  // sum of squares
  localparam int unsigned SQRT_STEPS = 34;
  localparam int unsigned DIV_STEPS  = 30;
  localparam int unsigned ITER_W     = 6;

  // port widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    K_TICK       = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_PUSH_FRONT = 3'd2,
    K_REPLACE    = 3'd3,
    K_SET_POS    = 3'd4
  } kind_e;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TARGET,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SQRT_STEP,
    OP_DECIDE,
    OP_DIV_STEP,
    OP_COMMIT
  } op_e;

  // which product the shared multiplier forms
  typedef enum logic [1:0] {
    MS_SQX,
    MS_SQY,
    MS_MVX,
    MS_MVY
  } msel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TARGET,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SQRT,
    ST_DECIDE,
    ST_DIV,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    op_e   op;
    msel_e msel;
  } cmd_t;

  typedef struct packed {
    logic tick_go;   // tick with a target and nonzero speed
    logic far;       // distance exceeds step
    logic out_busy;  // result register full and not taken
  } stat_t;

  // clamp a wide signed value to the 32-bit signed range
  function automatic logic [POS_W-1:0] sat32(input logic signed [35:0] v);
    logic [POS_W-1:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/wf2d_ctrl.sv
// Sequencer for the waypoint follower: steps the datapath through decode,
// squares, square root, divide and commit. Depends on wf2d_pkg.
module wf2d_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wf2d_pkg::stat_t stat_i,
  output wf2d_pkg::cmd_t  cmd_o
);

  wf2d_pkg::state_e state_q, state_d;
  wf2d_pkg::msel_e  msel_q, msel_d;
  logic [wf2d_pkg::ITER_W-1:0] iter_q, iter_d;

  // state, product selector and iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wf2d_pkg::ST_IDLE;
      msel_q  <= wf2d_pkg::MS_SQX;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      msel_q  <= msel_d;
      iter_q  <= iter_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    msel_d     = msel_q;
    iter_d     = iter_q;
    in_ready_o = 1'b0;
    cmd_o.op   = wf2d_pkg::OP_NONE;
    cmd_o.msel = msel_q;
    unique case (state_q)
      wf2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wf2d_pkg::OP_LATCH;
          state_d  = wf2d_pkg::ST_DECODE;
        end
      end
      wf2d_pkg::ST_DECODE: begin
        if (stat_i.tick_go) begin
          state_d = wf2d_pkg::ST_TARGET;
        end else if (!stat_i.out_busy) begin
          cmd_o.op = wf2d_pkg::OP_COMMIT;
          state_d  = wf2d_pkg::ST_IDLE;
        end
      end
      wf2d_pkg::ST_TARGET: begin
        cmd_o.op = wf2d_pkg::OP_TARGET;
        state_d  = wf2d_pkg::ST_DIFF;
      end
      wf2d_pkg::ST_DIFF: begin
        cmd_o.op = wf2d_pkg::OP_DIFF;
        msel_d   = wf2d_pkg::MS_SQX;
        state_d  = wf2d_pkg::ST_MUL_LO;
      end
      wf2d_pkg::ST_MUL_LO: begin
        cmd_o.op = wf2d_pkg::OP_MUL_LO;
        state_d  = wf2d_pkg::ST_MUL_HI;
      end
      wf2d_pkg::ST_MUL_HI: begin
        cmd_o.op = wf2d_pkg::OP_MUL_HI;
        unique case (msel_q)
          wf2d_pkg::MS_SQX: begin
            msel_d  = wf2d_pkg::MS_SQY;
            state_d = wf2d_pkg::ST_MUL_LO;
          end
          wf2d_pkg::MS_SQY: begin
            iter_d  = '0;
            state_d = wf2d_pkg::ST_SQRT;
          end
          wf2d_pkg::MS_MVX: begin
            msel_d  = wf2d_pkg::MS_MVY;
            state_d = wf2d_pkg::ST_MUL_LO;
          end
          default: begin
            state_d = wf2d_pkg::ST_COMMIT;
          end
        endcase
      end
      wf2d_pkg::ST_SQRT: begin
        cmd_o.op = wf2d_pkg::OP_SQRT_STEP;
        iter_d   = iter_q + 1'b1;
        if (iter_q == wf2d_pkg::ITER_W'(wf2d_pkg::SQRT_STEPS - 1)) begin
          state_d = wf2d_pkg::ST_DECIDE;
        end
      end
      wf2d_pkg::ST_DECIDE: begin
        cmd_o.op = wf2d_pkg::OP_DECIDE;
        iter_d   = '0;
        state_d  = stat_i.far ? wf2d_pkg::ST_DIV : wf2d_pkg::ST_COMMIT;
      end
      wf2d_pkg::ST_DIV: begin
        cmd_o.op = wf2d_pkg::OP_DIV_STEP;
        iter_d   = iter_q + 1'b1;
        if (iter_q == wf2d_pkg::ITER_W'(wf2d_pkg::DIV_STEPS - 1)) begin
          msel_d  = wf2d_pkg::MS_MVX;
          state_d = wf2d_pkg::ST_MUL_LO;
        end
      end
      wf2d_pkg::ST_COMMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = wf2d_pkg::OP_COMMIT;
          state_d  = wf2d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wf2d_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/wf2d_dp.sv
// Datapath of the waypoint follower: config registers, target queue memory,
// position, shared multiplier, square root, divider and result register.
// Depends on wf2d_pkg.
module wf2d_dp #(
  parameter int unsigned QUEUE_DEPTH = wf2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [wf2d_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wf2d_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [wf2d_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [wf2d_pkg::IN_USER_W-1:0]      in_user_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [wf2d_pkg::OUT_DATA_W-1:0]     out_data_o,
  input  wf2d_pkg::cmd_t                      cmd_i,
  output wf2d_pkg::stat_t                     stat_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  // configuration
  logic [wf2d_pkg::STEP_W-1:0] speed_q;
  logic [15:0]                 view_w_q, view_h_q;
  logic [30:0]                 half_w, half_h;

  // latched item
  logic [2:0]  kind_q;
  logic [31:0] tgt_x_q, tgt_y_q;
  logic [15:0] dt_q;

  // queue and position
  logic [63:0]   target_mem [QUEUE_DEPTH];
  logic [63:0]   rd_q;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;

  // tick arithmetic
  logic signed [33:0]           tx_q, ty_q;
  logic [wf2d_pkg::STEP_W-1:0]  step_q;
  logic [wf2d_pkg::MAG_W-1:0]   ax_q, ay_q;
  logic                         sgn_x_q, sgn_y_q;
  logic [50:0]                  plo_q;
  logic [wf2d_pkg::RAD_W-1:0]   rad_q;
  logic [wf2d_pkg::MAG_W-1:0]   sq_q;
  logic [34:0]                  sr_q;
  logic [wf2d_pkg::MAG_W-1:0]   dr_q;
  logic [wf2d_pkg::RATIO_W-1:0] ratio_q;
  logic                         far_q;
  logic [wf2d_pkg::MAG_W-1:0]   mvx_q, mvy_q;

  logic                         out_valid_q;
  logic [wf2d_pkg::OUT_DATA_W-1:0] out_data_q;

  assign half_w = {view_w_q, 15'b0};
  assign half_h = {view_h_q, 15'b0};

  // status to the controller
  logic tick_go;
  assign tick_go = (kind_q == wf2d_pkg::K_TICK) && (count_q != '0) && (speed_q != '0);
  assign stat_o.tick_go  = tick_go;
  assign stat_o.far      = sq_q > {3'b0, step_q};
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // configuration writes, always accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= '0;
      view_w_q <= '0;
      view_h_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wf2d_pkg::REG_MOVE_SPEED:  speed_q  <= cfg_data_i[wf2d_pkg::STEP_W-1:0];
        wf2d_pkg::REG_VIEW_WIDTH:  view_w_q <= cfg_data_i[15:0];
        wf2d_pkg::REG_VIEW_HEIGHT: view_h_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // shared 34x34 multiplier, two 34x17 halves
  logic [wf2d_pkg::MAG_W-1:0] mul_a, mul_b;
  logic [50:0]                mul_p;
  logic [67:0]                mul_full;
  always_comb begin
    case (cmd_i.msel)
      wf2d_pkg::MS_SQX: begin mul_a = ax_q; mul_b = ax_q; end
      wf2d_pkg::MS_SQY: begin mul_a = ay_q; mul_b = ay_q; end
      wf2d_pkg::MS_MVX: begin mul_a = ax_q; mul_b = {4'b0, ratio_q}; end
      default:          begin mul_a = ay_q; mul_b = {4'b0, ratio_q}; end
    endcase
    if (cmd_i.op == wf2d_pkg::OP_MUL_HI) begin
      mul_p = mul_a * {17'b0, mul_b[33:17]};
    end else begin
      mul_p = mul_a * {17'b0, mul_b[16:0]};
    end
    mul_full = {17'b0, plo_q} + {mul_p, 17'b0};
  end

  // differences to the target
  logic signed [34:0] dx_c, dy_c;
  assign dx_c = {tx_q[33], tx_q} - {{3{pos_x_q[31]}}, pos_x_q};
  assign dy_c = {ty_q[33], ty_q} - {{3{pos_y_q[31]}}, pos_y_q};

  logic [46:0] step_full;
  assign step_full = speed_q * dt_q;

  // square root and divide steps
  logic [36:0] sqrt_r, sqrt_t;
  logic [34:0] div_s;
  assign sqrt_r = {sr_q, rad_q[67:66]};
  assign sqrt_t = {1'b0, sq_q, 2'b01};
  assign div_s  = {dr_q, 1'b0};

  // queue pointers
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail_idx, prev_idx, next_idx;
  logic          q_full;
  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    end
    tail_idx = tail_sum[IW-1:0];
    prev_idx = (head_q == '0) ? IW'(QUEUE_DEPTH - 1) : head_q - 1'b1;
    next_idx = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    q_full   = count_q == CW'(QUEUE_DEPTH);
  end

  // commit: new queue, position and flags
  logic          mem_we, arrived_c, dropped_c;
  logic [IW-1:0] mem_waddr;
  logic signed [35:0] mv_x, mv_y;
  logic signed [33:0] set_x, set_y;
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    arrived_c = 1'b0;
    dropped_c = 1'b0;
    mv_x  = sgn_x_q ? -$signed({2'b0, mvx_q}) : $signed({2'b0, mvx_q});
    mv_y  = sgn_y_q ? -$signed({2'b0, mvy_q}) : $signed({2'b0, mvy_q});
    set_x = {{2{tgt_x_q[31]}}, tgt_x_q} - {3'b0, half_w};
    set_y = {{2{tgt_y_q[31]}}, tgt_y_q} - {3'b0, half_h};
    unique case (kind_q)
      wf2d_pkg::K_TICK: begin
        if (tick_go) begin
          if (far_q) begin
            pos_x_d = wf2d_pkg::sat32({{4{pos_x_q[31]}}, pos_x_q} + mv_x);
            pos_y_d = wf2d_pkg::sat32({{4{pos_y_q[31]}}, pos_y_q} + mv_y);
          end else begin
            pos_x_d   = wf2d_pkg::sat32({{2{tx_q[33]}}, tx_q});
            pos_y_d   = wf2d_pkg::sat32({{2{ty_q[33]}}, ty_q});
            head_d    = next_idx;
            count_d   = count_q - 1'b1;
            arrived_c = 1'b1;
          end
        end
      end
      wf2d_pkg::K_PUSH_BACK: begin
        if (q_full) begin
          dropped_c = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = tail_idx;
          count_d   = count_q + 1'b1;
        end
      end
      wf2d_pkg::K_PUSH_FRONT: begin
        if (q_full) begin
          dropped_c = 1'b1;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = prev_idx;
          head_d    = prev_idx;
          count_d   = count_q + 1'b1;
        end
      end
      wf2d_pkg::K_REPLACE: begin
        // empty queue: same as a push at the back
        mem_we = 1'b1;
        if (count_q == '0) begin
          mem_waddr = tail_idx;
          count_d   = count_q + 1'b1;
        end
      end
      wf2d_pkg::K_SET_POS: begin
        pos_x_d = wf2d_pkg::sat32({{2{set_x[33]}}, set_x});
        pos_y_d = wf2d_pkg::sat32({{2{set_y[33]}}, set_y});
      end
      default: ;
    endcase
  end

  // target memory, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wf2d_pkg::OP_COMMIT && mem_we) begin
      target_mem[mem_waddr] <= {tgt_y_q, tgt_x_q};
    end
    rd_q <= target_mem[head_q];
  end

  // queue pointers and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else if (cmd_i.op == wf2d_pkg::OP_COMMIT) begin
      head_q  <= head_d;
      count_q <= count_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      wf2d_pkg::OP_LATCH: begin
        kind_q  <= in_user_i;
        tgt_x_q <= in_data_i[31:0];
        tgt_y_q <= in_data_i[63:32];
        dt_q    <= in_data_i[79:64];
      end
      wf2d_pkg::OP_TARGET: begin
        tx_q   <= {{2{rd_q[31]}}, rd_q[31:0]} - {3'b0, half_w};
        ty_q   <= {{2{rd_q[63]}}, rd_q[63:32]} - {3'b0, half_h};
        step_q <= step_full[46:16];
      end
      wf2d_pkg::OP_DIFF: begin
        sgn_x_q <= dx_c[34];
        sgn_y_q <= dy_c[34];
        ax_q    <= dx_c[34] ? 34'(-dx_c) : dx_c[33:0];
        ay_q    <= dy_c[34] ? 34'(-dy_c) : dy_c[33:0];
        sq_q    <= '0;
        sr_q    <= '0;
      end
      wf2d_pkg::OP_MUL_LO: begin
        plo_q <= mul_p;
      end
      wf2d_pkg::OP_MUL_HI: begin
        case (cmd_i.msel)
          wf2d_pkg::MS_SQX: rad_q <= mul_full;
          wf2d_pkg::MS_SQY: rad_q <= rad_q + mul_full;
          wf2d_pkg::MS_MVX: mvx_q <= mul_full[63:30];
          default:          mvy_q <= mul_full[63:30];
        endcase
      end
      wf2d_pkg::OP_SQRT_STEP: begin
        // one result bit per cycle, two radicand bits in
        rad_q <= {rad_q[65:0], 2'b00};
        if (sqrt_r >= sqrt_t) begin
          sr_q <= 35'(sqrt_r - sqrt_t);
          sq_q <= {sq_q[32:0], 1'b1};
        end else begin
          sr_q <= sqrt_r[34:0];
          sq_q <= {sq_q[32:0], 1'b0};
        end
      end
      wf2d_pkg::OP_DECIDE: begin
        far_q   <= stat_o.far;
        dr_q    <= {3'b0, step_q};
        ratio_q <= '0;
      end
      wf2d_pkg::OP_DIV_STEP: begin
        // restoring division of step << 30 by the distance
        if (div_s >= {1'b0, sq_q}) begin
          dr_q    <= 34'(div_s - {1'b0, sq_q});
          ratio_q <= {ratio_q[28:0], 1'b1};
        end else begin
          dr_q    <= div_s[33:0];
          ratio_q <= {ratio_q[28:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // result register
  logic [CW+4:0] count_ext;
  assign count_ext = (CW+5)'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == wf2d_pkg::OP_COMMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wf2d_pkg::OP_COMMIT) begin
      out_data_q <= {1'b0, dropped_c, count_ext[4:0], arrived_c, pos_y_d, pos_x_d};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> sv/waypoint_follower_2d.sv
// Top level of the 2D waypoint follower: joins the controller and datapath.
// Depends on wf2d_pkg, wf2d_ctrl and wf2d_dp.
//
// Usage: items arrive on the s_axis stream (kind in tuser; target and frame
// time in tdata); each item yields exactly one word on m_axis carrying the
// view position, arrival and drop flags and the queue fill. Registers
// (speed, view width, view height) are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// Timing: one item at a time. Queue and position commands skip the tick
// arithmetic. A tick that reaches its target forms the squares on the
// 34x17 multiplier, used twice per product, and runs the 34-step square
// root; one that moves partway also needs the 30-step divider and two more
// products. The next word is accepted the cycle after a result is loaded.
// The input is accepted even while the previous result waits; if the
// receiver stalls, the block holds the new item until the output register
// frees. Reset clears the registers, position and queue; the queue memory
// itself is not cleared, since only entries holding targets are read.
module waypoint_follower_2d #(
  parameter int unsigned QUEUE_DEPTH = wf2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // target_x[31:0], target_y[63:32], delta_time[79:64]
  input  logic [wf2d_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[2:0]
  input  logic [wf2d_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_x[31:0], pos_y[63:32], arrived[64], queue_count[69:65], dropped[70]
  output logic [wf2d_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wf2d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wf2d_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  wf2d_pkg::cmd_t  cmd;
  wf2d_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  wf2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wf2d_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

>>> sv/wf2d_chk.sv
// Port-level checks for the waypoint follower, bound to the top level.
// Depends on wf2d_pkg and waypoint_follower_2d.
module wf2d_chk #(
  parameter int unsigned QUEUE_DEPTH = wf2d_pkg::QUEUE_DEPTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [wf2d_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input logic [wf2d_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wf2d_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [wf2d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [wf2d_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a word never both arrives and drops
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[64] && m_axis_tdata[70]))
    else $error("arrived and dropped both set");

  // queue fill within depth
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[69:65]) <= QUEUE_DEPTH)
    else $error("queue count above depth");

endmodule

bind waypoint_follower_2d wf2d_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_wf2d_chk (.*);
